/* sv/srt_pkg.sv */
// Package with widths, operation codes, status codes and record type of the date-ordered table.
package srt_pkg;
	localparam int TableDepth = 64;
	localparam int AddrW = $clog2(TableDepth);
	localparam int CountW = $clog2(TableDepth + 1);
	localparam int CodeW = 40;
	localparam int DateW = 23;
	localparam int PostW = 17;
	localparam int RecW = CodeW + DateW + PostW;

	localparam logic [2:0] FuncInsert = 3'd0;
	localparam logic [2:0] FuncSearch = 3'd1;
	localparam logic [2:0] FuncDelete = 3'd2;
	localparam logic [2:0] FuncRange = 3'd3;
	localparam logic [2:0] FuncList = 3'd4;

	localparam logic [1:0] StatusOk = 2'd0;
	localparam logic [1:0] StatusNone = 2'd1;
	localparam logic [1:0] StatusFull = 2'd2;

	typedef struct packed {
		logic [CodeW-1:0] code;
		logic [DateW-1:0] date;
		logic [PostW-1:0] postal;
	} rec_t;
endpackage

/* sv/srt_if.sv */
// Valid/ready channel interfaces for requests and results of the record table.
interface srt_req_if;
	import srt_pkg::*;
	logic valid;
	logic ready;
	logic [2:0] func;
	logic [CodeW-1:0] record_code;
	logic [DateW-1:0] birth_date;
	logic [DateW-1:0] date_upper;
	logic [PostW-1:0] postal_code;
	modport source(output valid, func, record_code, birth_date, date_upper, postal_code,
		input ready);
	modport sink(input valid, func, record_code, birth_date, date_upper, postal_code,
		output ready);
endinterface

interface srt_rsp_if;
	import srt_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [CodeW-1:0] out_code;
	logic [DateW-1:0] out_date;
	logic [PostW-1:0] out_postal;
	logic last;
	modport source(output valid, status, out_code, out_date, out_postal, last, input ready);
	modport sink(input valid, status, out_code, out_date, out_postal, last, output ready);
endinterface

/* sv/srt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module srt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/sorted_record_table_by_date.sv */
// Top level of the date-ordered record table with its sequencer.
//
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   func, record_code, birth_date, date_upper, postal_code
// rsp      out  valid/ready   status, out_code, out_date, out_postal, last
//
// Every step is one read or one write of the single record RAM, which a scan and
// a shift share. A range delete shifts the tail once per removed record.
// After reset the table is empty and ready at once; no clearing pass is run.
// A result waiting on rsp holds the sequencer; req is ready only between requests.
module sorted_record_table_by_date
	import srt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	srt_req_if.sink req,
	srt_rsp_if.source rsp
);
	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StScanRd = 4'd1;
	localparam logic [3:0] StScanChk = 4'd2;
	localparam logic [3:0] StInsRd = 4'd3;
	localparam logic [3:0] StInsWr = 4'd4;
	localparam logic [3:0] StInsPut = 4'd5;
	localparam logic [3:0] StRemRd = 4'd6;
	localparam logic [3:0] StRemWr = 4'd7;
	localparam logic [3:0] StOut = 4'd8;
	localparam logic [3:0] StEnd = 4'd9;

	logic [3:0] state_q;
	logic [2:0] func_q;
	rec_t key_q;
	logic [DateW-1:0] upper_q;
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] idx_q;
	logic [CountW-1:0] mv_q;
	logic found_q;
	logic [3:0] ret_q;

	logic we;
	logic [AddrW-1:0] waddr;
	logic [AddrW-1:0] raddr;
	rec_t wdata;
	rec_t rdata;
	rec_t out_q;
	rec_t pend_q;
	logic [1:0] status_q;
	logic last_q;
	logic valid_q;
	logic hit;

	srt_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign req.ready = (state_q == StIdle);
	assign rsp.valid = valid_q;
	assign rsp.status = status_q;
	assign rsp.out_code = out_q.code;
	assign rsp.out_date = out_q.date;
	assign rsp.out_postal = out_q.postal;
	assign rsp.last = last_q;

	always_comb begin
		case (func_q)
			FuncRange: hit = (rdata.date > key_q.date) && (rdata.date < upper_q);
			FuncList: hit = 1'b1;
			default: hit = (rdata.code == key_q.code);
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = mv_q[AddrW-1:0];
		wdata = rdata;
		raddr = idx_q[AddrW-1:0];
		case (state_q)
			StInsRd: raddr = AddrW'(mv_q - 1'b1);
			StInsWr: we = 1'b1;
			StInsPut: begin
				we = 1'b1;
				waddr = idx_q[AddrW-1:0];
				wdata = key_q;
			end
			StRemRd: raddr = AddrW'(mv_q + 1'b1);
			StRemWr: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			count_q <= '0;
			valid_q <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
			mv_q <= '0;
			func_q <= FuncInsert;
			ret_q <= StIdle;
			key_q <= '0;
			upper_q <= '0;
			out_q <= '0;
			pend_q <= '0;
			status_q <= StatusOk;
			last_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (req.valid) begin
						func_q <= req.func;
						key_q <= '{req.record_code, req.birth_date, req.postal_code};
						upper_q <= req.date_upper;
						idx_q <= '0;
						found_q <= 1'b0;
						if (req.func == FuncInsert || req.func == FuncSearch ||
							req.func == FuncDelete || req.func == FuncRange ||
							req.func == FuncList) begin
							state_q <= StScanRd;
						end
					end
				end
				StScanRd: begin
					if (idx_q == count_q) begin
						state_q <= StEnd;
						if (func_q == FuncInsert && count_q != CountW'(TableDepth)) begin
							mv_q <= count_q;
							state_q <= StInsRd;
						end
					end else begin
						state_q <= StScanChk;
					end
				end
				StScanChk: begin
					if (func_q == FuncInsert) begin
						if (count_q == CountW'(TableDepth)) begin
							state_q <= StEnd;
						end else if (rdata.date < key_q.date) begin
							idx_q <= idx_q + 1'b1;
							state_q <= StScanRd;
						end else begin
							mv_q <= count_q;
							state_q <= StInsRd;
						end
					end else if (hit) begin
						mv_q <= idx_q;
						state_q <= StOut;
						if (func_q == FuncList) begin
							ret_q <= StScanRd;
						end else if (func_q == FuncSearch) begin
							ret_q <= StIdle;
						end else begin
							ret_q <= StRemRd;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= StScanRd;
					end
				end
				StInsRd: begin
					state_q <= (mv_q == idx_q) ? StInsPut : StInsWr;
				end
				StInsWr: begin
					mv_q <= mv_q - 1'b1;
					state_q <= StInsRd;
				end
				StInsPut: begin
					count_q <= count_q + 1'b1;
					found_q <= 1'b1;
					state_q <= StEnd;
				end
				StRemRd: begin
					if (mv_q + 1'b1 >= count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= (func_q == FuncRange) ? StScanRd : StIdle;
					end else begin
						state_q <= StRemWr;
					end
				end
				StRemWr: begin
					mv_q <= mv_q + 1'b1;
					state_q <= StRemRd;
				end
				StOut: begin
					if (!valid_q) begin
						found_q <= 1'b1;
						state_q <= ret_q;
						status_q <= StatusOk;
						if (func_q == FuncRange) begin
							pend_q <= rdata;
							out_q <= pend_q;
							last_q <= 1'b0;
							valid_q <= found_q;
						end else begin
							out_q <= rdata;
							last_q <= (func_q != FuncList) || (idx_q + 1'b1 == count_q);
							valid_q <= 1'b1;
						end
						if (func_q == FuncList) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				StEnd: begin
					if (!valid_q) begin
						out_q <= '0;
						last_q <= 1'b1;
						if (func_q == FuncInsert) begin
							status_q <= found_q ? StatusOk : StatusFull;
						end else if (func_q == FuncRange && found_q) begin
							out_q <= pend_q;
							status_q <= StatusOk;
						end else begin
							status_q <= StatusNone;
						end
						valid_q <= (func_q == FuncInsert) || (func_q == FuncRange) || !found_q;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	ap_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(TableDepth)) else $error("entry count overflow");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_q))
		else $error("result changed while stalled");
	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.func <= FuncList |=> !req.ready)
		else $error("ready during work");
endmodule

/* dv/sorted_record_table_by_date_test.sv */
// Testbench for the date-ordered record table: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module sorted_record_table_by_date_test;
	import srt_pkg::*;

	typedef struct {
		logic [1:0] status;
		logic [CodeW-1:0] code;
		logic [DateW-1:0] date;
		logic [PostW-1:0] postal;
		logic last;
	} outcome_t;

	class table_scoreboard;
		rec_t rows[$];
		outcome_t pending[$];
		int mismatches;

		function void push(logic [1:0] st, rec_t r, logic lst);
			outcome_t o;
			o.status = st;
			o.code = r.code;
			o.date = r.date;
			o.postal = r.postal;
			o.last = lst;
			pending.push_back(o);
		endfunction

		function void note_request(logic [2:0] fn, logic [CodeW-1:0] code,
				logic [DateW-1:0] lo, logic [DateW-1:0] hi, logic [PostW-1:0] pc);
			rec_t blank;
			rec_t r;
			int pos;
			int hit;
			int cnt;
			blank = '0;
			hit = -1;
			cnt = 0;
			case (fn)
				FuncInsert: begin
					if (rows.size() >= TableDepth) begin
						push(StatusFull, blank, 1'b1);
					end else begin
						pos = 0;
						while (pos < rows.size() && rows[pos].date < lo) pos++;
						r.code = code;
						r.date = lo;
						r.postal = pc;
						rows.insert(pos, r);
						push(StatusOk, blank, 1'b1);
					end
				end
				FuncSearch, FuncDelete: begin
					foreach (rows[i]) if (hit < 0 && rows[i].code == code) hit = i;
					if (hit < 0) begin
						push(StatusNone, blank, 1'b1);
					end else begin
						push(StatusOk, rows[hit], 1'b1);
						if (fn == FuncDelete) rows.delete(hit);
					end
				end
				FuncRange: begin
					pos = 0;
					while (pos < rows.size()) begin
						if (rows[pos].date > lo && rows[pos].date < hi) begin
							push(StatusOk, rows[pos], 1'b0);
							rows.delete(pos);
							cnt++;
						end else begin
							pos++;
						end
					end
					if (cnt == 0) push(StatusNone, blank, 1'b1);
					else pending[$].last = 1'b1;
				end
				FuncList: begin
					foreach (rows[i]) push(StatusOk, rows[i], i == rows.size() - 1);
					if (rows.size() == 0) push(StatusNone, blank, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [1:0] st, logic [CodeW-1:0] code,
				logic [DateW-1:0] dt, logic [PostW-1:0] pc, logic lst);
			outcome_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result: status %0d code %h", st, code);
				return;
			end
			e = pending.pop_front();
			if (st !== e.status || code !== e.code || dt !== e.date || pc !== e.postal
					|| lst !== e.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected %0d %h %0d %0d %0d, got %0d %h %0d %0d %0d",
						e.status, e.code, e.date, e.postal, e.last, st, code, dt, pc, lst);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	srt_req_if req ();
	srt_rsp_if rsp ();
	table_scoreboard board;
	logic calm;
	int quiet_cycles;
	logic [CodeW-1:0] known_codes[$];

	sorted_record_table_by_date u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (req.valid && req.ready)
			board.note_request(req.func, req.record_code, req.birth_date, req.date_upper,
				req.postal_code);
		if (rsp.valid && rsp.ready)
			board.check_result(rsp.status, rsp.out_code, rsp.out_date, rsp.out_postal, rsp.last);
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("** sorted_record_table_by_date: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) rsp.ready <= 1'b0;
		else rsp.ready <= calm || ($urandom_range(99) >= 37);
	end

	task automatic send(logic [2:0] fn, logic [CodeW-1:0] code, logic [DateW-1:0] lo,
			logic [DateW-1:0] hi, logic [PostW-1:0] pc);
		while (!calm && $urandom_range(99) < 37) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= fn;
		req.record_code <= code;
		req.birth_date <= lo;
		req.date_upper <= hi;
		req.postal_code <= pc;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (fn == FuncInsert) known_codes.push_back(code);
	endtask

	function automatic logic [DateW-1:0] pick_date();
		return DateW'($urandom_range(2030, 1900) * 512 + $urandom_range(12, 1) * 32
			+ $urandom_range(31, 1));
	endfunction

	function automatic logic [CodeW-1:0] pick_code();
		if (known_codes.size() > 0 && $urandom_range(3) != 0)
			return known_codes[$urandom_range(known_codes.size() - 1)];
		return {$urandom(), 8'($urandom())};
	endfunction

	initial begin
		logic [DateW-1:0] a;
		logic [DateW-1:0] b;
		int k;
		board = new();
		calm = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FuncList;
		req.record_code = '0;
		req.birth_date = '0;
		req.date_upper = '0;
		req.postal_code = '0;
		rsp.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(FuncList, '0, '0, '0, '0);
		send(FuncSearch, 40'h4142434445, '0, '0, '0);
		send(FuncDelete, 40'h4142434445, '0, '0, '0);
		send(FuncRange, '0, '0, '1, '0);
		send(FuncInsert, '1, '1, '0, '1);
		send(FuncInsert, '0, '0, '1, '0);
		send(FuncInsert, 40'h4142434445, 23'd1000000, '0, 17'd99999);
		send(FuncInsert, 40'h5a5a5a5a5a, 23'd1000000, '0, 17'd12345);
		send(3'd5, '1, '1, '1, '1);
		send(3'd7, '0, '0, '0, '0);
		send(FuncList, '0, '0, '0, '0);
		send(FuncSearch, 40'h4142434445, '0, '0, '0);
		send(FuncSearch, '1, '0, '0, '0);
		send(FuncDelete, '0, '0, '0, '0);
		send(FuncRange, '0, 23'd999999, 23'd1000001, '0);
		send(FuncRange, '0, '0, '1, '0);
		for (k = 0; k < 65; k++)
			send(FuncInsert, {$urandom(), 8'($urandom())}, pick_date(), '0,
				PostW'($urandom_range(99999)));
		send(FuncList, '0, '0, '0, '0);
		send(FuncRange, '0, '0, '1, '0);

		for (k = 0; k < 127; k++) begin
			calm = (k >= 60 && k < 100);
			a = pick_date();
			b = pick_date();
			case ($urandom_range(9))
				0, 1, 2, 3: send(FuncInsert, ($urandom_range(3) == 0) ? pick_code()
					: {$urandom(), 8'($urandom())}, a, '1 ^ a, PostW'($urandom_range(99999)));
				4: send(FuncSearch, pick_code(), a, b, '1);
				5, 6: send(FuncDelete, pick_code(), a, b, '0);
				7: send(FuncRange, pick_code(), (a < b) ? a : b, (a < b) ? b : a, '1);
				8: send(FuncList, pick_code(), a, b, '0);
				default: send(3'($urandom_range(7, 5)), pick_code(), a, b, '1);
			endcase
		end
		req.valid <= 1'b0;
		calm = 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("** sorted_record_table_by_date: PASSED **");
		else
			$display("** sorted_record_table_by_date: FAILED **");
		$finish;
	end
endmodule

/* files.f */
sv/srt_pkg.sv
sv/srt_if.sv
sv/srt_ram.sv
sv/sorted_record_table_by_date.sv
dv/sorted_record_table_by_date_test.sv
